>>> design/rcpwm_pkg.sv
// ----------------------------------------------------------------------------
// RC PWM decoder package
// Shared types and constants for the RC PWM channel decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rcpwm_pkg;

    localparam int MAX_CH    = 3;
    localparam int HOLD_BITS = 21;
    localparam int POS_BITS  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 21;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SWITCH_MARGIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS    = 2'd3;

    localparam logic [15:0]          PULSE_MIN_RST     = 16'd1000;
    localparam logic [15:0]          PULSE_MAX_RST     = 16'd2000;
    localparam logic [15:0]          SWITCH_MARGIN_RST = 16'd200;
    localparam logic [HOLD_BITS-1:0] HOLD_TICKS_RST    = 21'd1000000;

    localparam logic [POS_BITS-1:0]  POS_SAT_HIGH = 16'h7FFF;
    localparam logic [POS_BITS-1:0]  POS_SAT_LOW  = 16'h8000;

    typedef enum logic [1:0] {
        CLS_LOW  = 2'd0,
        CLS_HIGH = 2'd1,
        CLS_MID  = 2'd2
    } cls_t;

    typedef struct packed {
        logic [15:0]          pulse_min;
        logic [15:0]          pulse_max;
        logic [15:0]          switch_margin;
        logic [HOLD_BITS-1:0] hold_ticks;
    } cfg_t;

    typedef struct packed {
        cls_t cls;
        logic held_high;
        logic held_low;
    } chan_status_t;

endpackage

`default_nettype wire

>>> design/rc_pwm_channel_decoder.sv
// ----------------------------------------------------------------------------
// RC PWM channel decoder
// Decodes the pulse widths of up to three RC receiver channels.
// ----------------------------------------------------------------------------
// Each input transfer is one microsecond tick carrying the sampled pin levels.
// Per channel the block times rising-to-falling spans, classifies the last
// width as low, high or middle, raises held flags once a class has persisted
// beyond hold_ticks, and reports the position (width - pulse_min) /
// (pulse_max - pulse_min) in signed Q2.14, saturated. One result is produced
// per tick. A tick in which no pulse ends goes straight from the queue to the
// result register; otherwise each channel whose pulse ends passes in turn
// through a prepare step and the shared bit-serial divider, and an emit step
// then loads the result register. The first tick after reset or after any
// register write recomputes every channel. A two-entry queue separates the
// edge tracker from the divider, and the result sits in an output register,
// so ticks keep being accepted while a result waits, until the queue fills.
// Configuration registers: 0 pulse_min, 1 pulse_max, 2 switch_margin,
// 3 hold_ticks; write them only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module rc_pwm_channel_decoder #(
    parameter int CHANNELS   = 3,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,

    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [rcpwm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [rcpwm_pkg::CFG_DAT_W-1:0]      cfg_data,

    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic                                 s_ch0_level,
    input  wire logic                                 s_ch1_level,
    input  wire logic                                 s_ch2_level,

    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic signed [15:0]                        m_ch0_position,
    output logic [1:0]                                m_ch0_class,
    output logic                                      m_ch0_held_high,
    output logic                                      m_ch0_held_low,
    output logic signed [15:0]                        m_ch1_position,
    output logic [1:0]                                m_ch1_class,
    output logic                                      m_ch1_held_high,
    output logic                                      m_ch1_held_low,
    output logic signed [15:0]                        m_ch2_position,
    output logic [1:0]                                m_ch2_class,
    output logic                                      m_ch2_held_high,
    output logic                                      m_ch2_held_low
);

    import rcpwm_pkg::*;

    localparam int STAT_W  = $bits(chan_status_t);
    localparam int ENTRY_W = MAX_CH + MAX_CH * COUNT_BITS + MAX_CH * STAT_W;

    cfg_t                              cfg_reg;
    logic                              cfg_wr;
    logic                              in_fire;
    logic                              q_full, q_valid, q_pop;
    logic [MAX_CH-1:0]                 f_mask, q_mask;
    logic [MAX_CH-1:0][COUNT_BITS-1:0] f_widths, q_widths;
    chan_status_t [MAX_CH-1:0]         f_status, q_status;
    logic [ENTRY_W-1:0]                q_wr_data, q_rd_data;
    logic [MAX_CH-1:0][POS_BITS-1:0]   out_pos;
    chan_status_t [MAX_CH-1:0]         out_status;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign s_ready   = !q_full;
    assign in_fire   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pulse_min     <= PULSE_MIN_RST;
            cfg_reg.pulse_max     <= PULSE_MAX_RST;
            cfg_reg.switch_margin <= SWITCH_MARGIN_RST;
            cfg_reg.hold_ticks    <= HOLD_TICKS_RST;
        end else if (cfg_wr) begin
            unique case (cfg_index)
                REG_PULSE_MIN:     cfg_reg.pulse_min     <= cfg_data[15:0];
                REG_PULSE_MAX:     cfg_reg.pulse_max     <= cfg_data[15:0];
                REG_SWITCH_MARGIN: cfg_reg.switch_margin <= cfg_data[15:0];
                REG_HOLD_TICKS:    cfg_reg.hold_ticks    <= cfg_data[HOLD_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    rcpwm_front #(
        .CHANNELS   (CHANNELS),
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .cfg_wr   (cfg_wr),
        .in_fire  (in_fire),
        .levels   ({s_ch2_level, s_ch1_level, s_ch0_level}),
        .div_mask (f_mask),
        .widths   (f_widths),
        .status   (f_status)
    );

    assign q_wr_data = {f_mask, f_widths, f_status};
    assign {q_mask, q_widths, q_status} = q_rd_data;

    rcpwm_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (2)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_fire),
        .wr_data   (q_wr_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .rd_data   (q_rd_data)
    );

    rcpwm_back #(
        .CHANNELS   (CHANNELS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .q_valid    (q_valid),
        .q_mask     (q_mask),
        .q_widths   (q_widths),
        .q_status   (q_status),
        .q_pop      (q_pop),
        .m_ready    (m_ready),
        .m_valid    (m_valid),
        .m_position (out_pos),
        .m_status   (out_status)
    );

    assign m_ch0_position  = $signed(out_pos[0]);
    assign m_ch0_class     = out_status[0].cls;
    assign m_ch0_held_high = out_status[0].held_high;
    assign m_ch0_held_low  = out_status[0].held_low;
    assign m_ch1_position  = $signed(out_pos[1]);
    assign m_ch1_class     = out_status[1].cls;
    assign m_ch1_held_high = out_status[1].held_high;
    assign m_ch1_held_low  = out_status[1].held_low;
    assign m_ch2_position  = $signed(out_pos[2]);
    assign m_ch2_class     = out_status[2].cls;
    assign m_ch2_held_high = out_status[2].held_high;
    assign m_ch2_held_low  = out_status[2].held_low;

endmodule

`default_nettype wire

>>> design/rcpwm_fifo.sv
// ----------------------------------------------------------------------------
// RC PWM decoder queue
// Small register queue between the edge tracker and the position divider.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpwm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  not_empty,
    output logic [WIDTH-1:0]      rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    assign full      = (count_reg == (PTR_W+1)'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                mem_reg[wr_ptr_reg] <= wr_data;
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> design/rcpwm_front.sv
// ----------------------------------------------------------------------------
// RC PWM decoder front end
// Per-channel edge tracking, width timing, classification and hold timing.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpwm_front #(
    parameter int CHANNELS   = 3,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire rcpwm_pkg::cfg_t                         cfg,
    input  wire logic                                    cfg_wr,
    input  wire logic                                    in_fire,
    input  wire logic [rcpwm_pkg::MAX_CH-1:0]            levels,
    output logic [rcpwm_pkg::MAX_CH-1:0]                 div_mask,
    output logic [rcpwm_pkg::MAX_CH-1:0][COUNT_BITS-1:0] widths,
    output rcpwm_pkg::chan_status_t [rcpwm_pkg::MAX_CH-1:0] status
);

    import rcpwm_pkg::*;

    localparam int CMP_W = ((COUNT_BITS > 17) ? COUNT_BITS : 17) + 1;

    logic dirty_reg;

    // Thresholds shared by all channels
    logic [16:0]              lo_sum;
    logic signed [16:0]       hi_diff;
    logic signed [CMP_W-1:0]  lo_thr, hi_thr;

    assign lo_sum  = {1'b0, cfg.pulse_min} + {1'b0, cfg.switch_margin};
    assign hi_diff = $signed({1'b0, cfg.pulse_max}) - $signed({1'b0, cfg.switch_margin});
    assign lo_thr  = $signed({{(CMP_W-17){1'b0}}, lo_sum});
    assign hi_thr  = $signed({{(CMP_W-17){hi_diff[16]}}, hi_diff});

    // Positions must be recomputed once after reset and after any register write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dirty_reg <= 1'b1;
        end else if (cfg_wr) begin
            dirty_reg <= 1'b1;
        end else if (in_fire) begin
            dirty_reg <= 1'b0;
        end
    end

    for (genvar c = 0; c < MAX_CH; c++) begin : g_ch
        if (c < CHANNELS) begin : g_act
            logic                  wait_reg, wait_next;
            logic                  prev_reg;
            logic [COUNT_BITS-1:0] cnt_reg, cnt_next, cnt_inc;
            logic [COUNT_BITS-1:0] last_reg, last_next;
            cls_t                  cls_reg, cls_next, cls_new;
            logic [HOLD_BITS-1:0]  hold_reg, hold_next;
            logic                  rise, fall, ended, changed, held;
            logic signed [CMP_W-1:0] w_s;

            assign cnt_inc = (cnt_reg == '1) ? cnt_reg : cnt_reg + 1'b1;
            assign w_s     = $signed({{(CMP_W-COUNT_BITS){1'b0}}, cnt_inc});
            assign cls_new = (w_s < lo_thr) ? CLS_LOW : ((w_s > hi_thr) ? CLS_HIGH : CLS_MID);

            always_comb begin
                rise      = levels[c] & ~prev_reg;
                fall      = ~levels[c] & prev_reg;
                wait_next = wait_reg;
                cnt_next  = cnt_reg;
                last_next = last_reg;
                cls_next  = cls_reg;
                ended     = 1'b0;
                if (!wait_reg) begin
                    if (rise) begin
                        cnt_next  = '0;
                        wait_next = 1'b1;
                    end
                end else begin
                    cnt_next = cnt_inc;
                    if (fall) begin
                        last_next = cnt_inc;
                        cls_next  = cls_new;
                        wait_next = 1'b0;
                        ended     = 1'b1;
                    end
                end
                changed = ended && (cls_next != cls_reg);
                if (changed) begin
                    hold_next = '0;
                end else if (hold_reg == '1) begin
                    hold_next = hold_reg;
                end else begin
                    hold_next = hold_reg + 1'b1;
                end
                held = (hold_next > cfg.hold_ticks);
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    wait_reg <= 1'b1;
                    prev_reg <= 1'b0;
                    cnt_reg  <= '0;
                    last_reg <= '0;
                    cls_reg  <= CLS_LOW;
                    hold_reg <= '0;
                end else if (in_fire) begin
                    wait_reg <= wait_next;
                    prev_reg <= levels[c];
                    cnt_reg  <= cnt_next;
                    last_reg <= last_next;
                    cls_reg  <= cls_next;
                    hold_reg <= hold_next;
                end
            end

            assign div_mask[c]         = ended | dirty_reg;
            assign widths[c]           = last_next;
            assign status[c].cls       = cls_next;
            assign status[c].held_high = held && (cls_next == CLS_HIGH);
            assign status[c].held_low  = held && (cls_next == CLS_LOW);
        end else begin : g_off
            assign div_mask[c] = 1'b0;
            assign widths[c]   = '0;
            assign status[c]   = '0;
        end
    end

endmodule

`default_nettype wire

>>> design/rcpwm_back.sv
// ----------------------------------------------------------------------------
// RC PWM decoder back end
// Shared serial position divider, used for each channel in turn, and the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpwm_back #(
    parameter int CHANNELS   = 3,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire rcpwm_pkg::cfg_t                         cfg,
    input  wire logic                                    q_valid,
    input  wire logic [rcpwm_pkg::MAX_CH-1:0]            q_mask,
    input  wire logic [rcpwm_pkg::MAX_CH-1:0][COUNT_BITS-1:0] q_widths,
    input  wire rcpwm_pkg::chan_status_t [rcpwm_pkg::MAX_CH-1:0] q_status,
    output logic                                         q_pop,
    input  wire logic                                    m_ready,
    output logic                                         m_valid,
    output logic [rcpwm_pkg::MAX_CH-1:0][rcpwm_pkg::POS_BITS-1:0] m_position,
    output rcpwm_pkg::chan_status_t [rcpwm_pkg::MAX_CH-1:0] m_status
);

    import rcpwm_pkg::*;

    localparam int NUM_W = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;
    localparam int MAG_W = NUM_W - 1;
    localparam int DW    = ((MAG_W + 14) > 32) ? (MAG_W + 14) : 32;
    localparam int CH_W  = $clog2(MAX_CH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_EMIT
    } state_t;

    state_t                              state_reg;
    logic [MAX_CH-1:0]                   mask_reg;
    logic [MAX_CH-1:0][COUNT_BITS-1:0]   width_reg;
    chan_status_t [MAX_CH-1:0]           status_reg;
    logic [CH_W-1:0]                     ch_reg;
    logic [POS_BITS-1:0]                 pos_reg [MAX_CH];
    logic [DW-1:0]                       rem_reg;
    logic [30:0]                         dsh_reg;
    logic [POS_BITS-1:0]                 quo_reg;
    logic [3:0]                          step_reg;
    logic                                neg_reg, ovf_reg, zero_reg;
    logic                                m_valid_reg;
    logic [MAX_CH-1:0][POS_BITS-1:0]     m_pos_reg;
    chan_status_t [MAX_CH-1:0]           m_status_reg;

    logic                        out_free;
    logic                        m_load;
    logic [COUNT_BITS-1:0]       sel_w;
    logic signed [NUM_W-1:0]     num_s, num_n;
    logic [MAG_W-1:0]            num_mag;
    logic signed [16:0]          den_s, den_n;
    logic [15:0]                 den_mag;
    logic [DW-1:0]               dvd, dcmp;
    logic                        take;
    logic [POS_BITS-1:0]         quo_fin, pos_fin;
    logic [MAX_CH-1:0]           mask_left;

    function automatic logic [CH_W-1:0] first_ch(input logic [MAX_CH-1:0] m);
        logic [CH_W-1:0] idx;
        idx = '0;
        for (int i = MAX_CH - 1; i >= 0; i--) begin
            if (m[i]) begin
                idx = CH_W'(i);
            end
        end
        return idx;
    endfunction

    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = (state_reg == S_IDLE) && q_valid && ((q_mask != '0) || out_free);
    assign m_load   = ((state_reg == S_IDLE) && q_pop && (q_mask == '0))
                   || ((state_reg == S_EMIT) && out_free);

    // Operand setup for the selected channel
    assign sel_w   = width_reg[ch_reg];
    assign num_s   = $signed({{(NUM_W-COUNT_BITS){1'b0}}, sel_w})
                   - $signed({{(NUM_W-16){1'b0}}, cfg.pulse_min});
    assign num_n   = -num_s;
    assign num_mag = num_s[NUM_W-1] ? num_n[MAG_W-1:0] : num_s[MAG_W-1:0];
    assign den_s   = $signed({1'b0, cfg.pulse_max}) - $signed({1'b0, cfg.pulse_min});
    assign den_n   = -den_s;
    assign den_mag = den_s[16] ? den_n[15:0] : den_s[15:0];
    assign dvd     = DW'({num_mag, 14'd0});
    assign dcmp    = DW'({den_mag, 16'd0});

    // One quotient bit per cycle
    assign take    = (rem_reg >= DW'(dsh_reg));
    assign quo_fin = {quo_reg[POS_BITS-2:0], take};

    always_comb begin
        if (zero_reg) begin
            pos_fin = '0;
        end else if (neg_reg) begin
            pos_fin = (ovf_reg || quo_fin[POS_BITS-1]) ? POS_SAT_LOW : (~quo_fin + 1'b1);
        end else begin
            pos_fin = (ovf_reg || quo_fin[POS_BITS-1]) ? POS_SAT_HIGH : quo_fin;
        end
    end

    always_comb begin
        mask_left         = mask_reg;
        mask_left[ch_reg] = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !m_load) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (q_pop) begin
                        if (q_mask == '0) begin
                            m_valid_reg  <= 1'b1;
                            m_status_reg <= q_status;
                            for (int c = 0; c < MAX_CH; c++) begin
                                m_pos_reg[c] <= (c < CHANNELS) ? pos_reg[c] : '0;
                            end
                        end else begin
                            mask_reg   <= q_mask;
                            width_reg  <= q_widths;
                            status_reg <= q_status;
                            ch_reg     <= first_ch(q_mask);
                            state_reg  <= S_PREP;
                        end
                    end
                end
                S_PREP: begin
                    rem_reg   <= dvd;
                    dsh_reg   <= {den_mag, 15'd0};
                    quo_reg   <= '0;
                    step_reg  <= 4'd15;
                    neg_reg   <= num_s[NUM_W-1] ^ den_s[16];
                    ovf_reg   <= (dvd >= dcmp);
                    zero_reg  <= (den_s == '0);
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (take) begin
                        rem_reg <= rem_reg - DW'(dsh_reg);
                    end
                    dsh_reg  <= dsh_reg >> 1;
                    quo_reg  <= quo_fin;
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == '0) begin
                        pos_reg[ch_reg] <= pos_fin;
                        mask_reg        <= mask_left;
                        if (mask_left != '0) begin
                            ch_reg    <= first_ch(mask_left);
                            state_reg <= S_PREP;
                        end else begin
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= status_reg;
                        for (int c = 0; c < MAX_CH; c++) begin
                            m_pos_reg[c] <= (c < CHANNELS) ? pos_reg[c] : '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_position = m_pos_reg;
    assign m_status   = m_status_reg;

endmodule

`default_nettype wire

>>> tb/tb_rc_pwm_channel_decoder.sv
// ----------------------------------------------------------------------------
// RC PWM channel decoder testbench
// Feeds microsecond ticks of three pin levels through the input channel and
// checks every result transfer against a cycle-free model of the decoder:
// edge timing, width classes, held flags and the Q2.14 position. Register
// settings change between phases, while the decoder is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rc_pwm_channel_decoder;

    timeunit 1ns;
    timeprecision 1ps;

    import rcpwm_pkg::*;

    localparam int          HALF_PERIOD = 6;
    localparam int          CYCLE_LIMIT = 600000;
    localparam int          DRAIN_WAIT  = 64;
    localparam logic [15:0] WIDTH_LIMIT = 16'hFFFF;
    localparam logic [HOLD_BITS-1:0] HOLD_LIMIT = '1;
    localparam longint      Q_ONE       = 16384;
    localparam int          REPORT_CAP  = 100;

    typedef struct packed {
        logic [POS_BITS-1:0] position;
        cls_t                cls;
        logic                held_high;
        logic                held_low;
    } chan_res_t;

    typedef chan_res_t [MAX_CH-1:0] tick_res_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_PULSE_MIN;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    logic s_valid     = 1'b0;
    logic s_ready;
    logic s_ch0_level = 1'b0;
    logic s_ch1_level = 1'b0;
    logic s_ch2_level = 1'b0;

    logic                m_valid;
    logic                m_ready = 1'b0;
    logic signed [15:0]  m_ch0_position, m_ch1_position, m_ch2_position;
    logic [1:0]          m_ch0_class, m_ch1_class, m_ch2_class;
    logic                m_ch0_held_high, m_ch1_held_high, m_ch2_held_high;
    logic                m_ch0_held_low, m_ch1_held_low, m_ch2_held_low;

    rc_pwm_channel_decoder uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_ch0_level     (s_ch0_level),
        .s_ch1_level     (s_ch1_level),
        .s_ch2_level     (s_ch2_level),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_ch0_position  (m_ch0_position),
        .m_ch0_class     (m_ch0_class),
        .m_ch0_held_high (m_ch0_held_high),
        .m_ch0_held_low  (m_ch0_held_low),
        .m_ch1_position  (m_ch1_position),
        .m_ch1_class     (m_ch1_class),
        .m_ch1_held_high (m_ch1_held_high),
        .m_ch1_held_low  (m_ch1_held_low),
        .m_ch2_position  (m_ch2_position),
        .m_ch2_class     (m_ch2_class),
        .m_ch2_held_high (m_ch2_held_high),
        .m_ch2_held_low  (m_ch2_held_low)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Register copies seen by the decoder model
    logic [15:0]          cfg_min    = PULSE_MIN_RST;
    logic [15:0]          cfg_max    = PULSE_MAX_RST;
    logic [15:0]          cfg_margin = SWITCH_MARGIN_RST;
    logic [HOLD_BITS-1:0] cfg_hold   = HOLD_TICKS_RST;

    // Per-channel decoder state
    logic                 timing     [MAX_CH] = '{default: 1'b1};
    logic                 prev_lvl   [MAX_CH] = '{default: 1'b0};
    logic [15:0]          span_cnt   [MAX_CH] = '{default: '0};
    logic [15:0]          pulse_w    [MAX_CH] = '{default: '0};
    cls_t                 cur_cls    [MAX_CH] = '{default: CLS_LOW};
    logic [HOLD_BITS-1:0] stable_cnt [MAX_CH] = '{default: '0};

    // Pulse train generator state
    logic gen_lvl    [MAX_CH] = '{default: 1'b0};
    int   gen_left   [MAX_CH] = '{default: 0};
    int   gen_last_w [MAX_CH] = '{default: 0};

    logic [2:0] tick_q [$];
    tick_res_t  decoded_q [$];

    logic in_fire   = 1'b0;
    bit   calm      = 1'b0;
    int   err_cnt   = 0;
    int   n_results = 0;
    int   n_held    = 0;
    int   n_sat     = 0;
    int   n_settings = 1;
    int   cycle_cnt = 0;

    function automatic cls_t classify(logic [15:0] w);
        if (longint'(w) < longint'(cfg_min) + longint'(cfg_margin))
            return CLS_LOW;
        if (longint'(w) > longint'(cfg_max) - longint'(cfg_margin))
            return CLS_HIGH;
        return CLS_MID;
    endfunction

    function automatic logic [POS_BITS-1:0] norm_position(logic [15:0] w);
        longint span;
        longint q;
        span = longint'(cfg_max) - longint'(cfg_min);
        if (span == 0)
            return '0;
        q = ((longint'(w) - longint'(cfg_min)) * Q_ONE) / span;
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return POS_BITS'(q);
    endfunction

    function automatic tick_res_t decode_tick(logic [2:0] lv);
        tick_res_t r;
        logic      rise, fall, changed, held;
        cls_t      k;
        for (int c = 0; c < MAX_CH; c++) begin
            rise    = lv[c] && !prev_lvl[c];
            fall    = !lv[c] && prev_lvl[c];
            changed = 1'b0;
            if (!timing[c]) begin
                if (rise) begin
                    span_cnt[c] = '0;
                    timing[c]   = 1'b1;
                end
            end else begin
                // a rise while timing is ignored; only a fall ends the span
                if (span_cnt[c] != WIDTH_LIMIT)
                    span_cnt[c]++;
                if (fall) begin
                    pulse_w[c] = span_cnt[c];
                    k          = classify(pulse_w[c]);
                    changed    = (k != cur_cls[c]);
                    cur_cls[c] = k;
                    timing[c]  = 1'b0;
                end
            end
            prev_lvl[c] = lv[c];
            if (changed)
                stable_cnt[c] = '0;
            else if (stable_cnt[c] != HOLD_LIMIT)
                stable_cnt[c]++;
            held = stable_cnt[c] > cfg_hold;
            r[c] = '{norm_position(pulse_w[c]), cur_cls[c],
                     held && cur_cls[c] == CLS_HIGH, held && cur_cls[c] == CLS_LOW};
        end
        return r;
    endfunction

    function automatic bit go_ahead();
        return calm || $urandom_range(99) >= 12;
    endfunction

    function automatic int pick_width(int c);
        int lo, hi, w, r;
        lo = (cfg_min < cfg_max) ? cfg_min : cfg_max;
        hi = (cfg_min < cfg_max) ? cfg_max : cfg_min;
        if (hi > 80) begin
            lo = 1;
            hi = 80;
        end
        lo = (lo > 4) ? lo - 3 : 1;
        r  = $urandom_range(99);
        if (r < 45 && gen_last_w[c] != 0)
            w = gen_last_w[c] + $urandom_range(2) - 1;
        else if (r < 85)
            w = $urandom_range(hi + 3, lo);
        else if (r < 93)
            w = 1;
        else
            w = $urandom_range(3 * hi + 4, 1);
        if (w < 1)
            w = 1;
        gen_last_w[c] = w;
        return w;
    endfunction

    // Queue n ticks of pulse trains, with a sprinkle of single-tick glitches
    task automatic queue_ticks(int n);
        logic [2:0] lv;
        repeat (n) begin
            for (int c = 0; c < MAX_CH; c++) begin
                if (gen_left[c] == 0) begin
                    gen_lvl[c]  = !gen_lvl[c];
                    gen_left[c] = gen_lvl[c] ? pick_width(c) : $urandom_range(12, 1);
                end
                gen_left[c]--;
                lv[c] = gen_lvl[c];
            end
            if ($urandom_range(99) < 3)
                lv[$urandom_range(MAX_CH - 1)] ^= 1'b1;
            tick_q.push_back(lv);
        end
    endtask

    task automatic settle();
        do
            @(posedge aclk);
        while (tick_q.size() != 0 || s_valid || decoded_q.size() != 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge aclk);
        while (!cfg_ready);
        case (idx)
            REG_PULSE_MIN:     cfg_min    = val[15:0];
            REG_PULSE_MAX:     cfg_max    = val[15:0];
            REG_SWITCH_MARGIN: cfg_margin = val[15:0];
            REG_HOLD_TICKS:    cfg_hold   = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Upper data bits of the 16-bit registers are junk and must be dropped
    task automatic apply_setting(logic [15:0] mn, logic [15:0] mx, logic [15:0] mg,
                                 logic [HOLD_BITS-1:0] hold);
        write_reg(REG_PULSE_MIN, {5'($urandom), mn});
        write_reg(REG_PULSE_MAX, {5'($urandom), mx});
        write_reg(REG_SWITCH_MARGIN, {5'($urandom), mg});
        write_reg(REG_HOLD_TICKS, hold);
        n_settings++;
    endtask

    function automatic void report(string what, int c, int want, int got);
        err_cnt++;
        if (err_cnt <= REPORT_CAP)
            $display("%0t ch%0d %s: expected %0d, got %0d", $time, c, what, want, got);
    endfunction

    // Driver: present queued ticks, idle and stall at random
    always @(negedge aclk) begin : tick_driver
        logic [2:0] lv;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_fire) begin
            if (tick_q.size() != 0 && go_ahead()) begin
                lv = tick_q.pop_front();
                s_valid     <= 1'b1;
                s_ch0_level <= lv[0];
                s_ch1_level <= lv[1];
                s_ch2_level <= lv[2];
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= go_ahead();
    end

    // Monitor: predict on each tick transfer, check each result transfer
    always @(posedge aclk) begin : result_monitor
        tick_res_t got;
        tick_res_t want;
        in_fire = aresetn && s_valid && s_ready;
        if (in_fire)
            decoded_q.push_back(decode_tick({s_ch2_level, s_ch1_level, s_ch0_level}));
        if (aresetn && m_valid && m_ready) begin
            got[0] = '{m_ch0_position, cls_t'(m_ch0_class), m_ch0_held_high, m_ch0_held_low};
            got[1] = '{m_ch1_position, cls_t'(m_ch1_class), m_ch1_held_high, m_ch1_held_low};
            got[2] = '{m_ch2_position, cls_t'(m_ch2_class), m_ch2_held_high, m_ch2_held_low};
            if (decoded_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= REPORT_CAP)
                    $display("%0t unexpected result transfer: expected none, got %h",
                             $time, got);
            end else begin
                want = decoded_q.pop_front();
                n_results++;
                for (int c = 0; c < MAX_CH; c++) begin
                    if (want[c].held_high || want[c].held_low)
                        n_held++;
                    if (want[c].position == POS_SAT_HIGH || want[c].position == POS_SAT_LOW)
                        n_sat++;
                    if (got[c].position !== want[c].position)
                        report("position", c, $signed(want[c].position),
                               $signed(got[c].position));
                    if (got[c].cls !== want[c].cls)
                        report("class", c, want[c].cls, got[c].cls);
                    if (got[c].held_high !== want[c].held_high)
                        report("held_high", c, want[c].held_high, got[c].held_high);
                    if (got[c].held_low !== want[c].held_low)
                        report("held_low", c, want[c].held_low, got[c].held_low);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, decoded_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings: a rise while still timing from reset, then short pulses
        tick_q = '{3'b000, 3'b111, 3'b111, 3'b000, 3'b010, 3'b101, 3'b000,
                   3'b111, 3'b000};
        settle();

        // Narrow window, zero hold: one width of each class, then held flags
        apply_setting(16'd2, 16'd6, 16'd1, '0);
        tick_q = '{3'b111, 3'b110, 3'b110, 3'b110, 3'b100, 3'b100, 3'b100, 3'b100,
                   3'b000, 3'b000, 3'b111, 3'b000, 3'b000, 3'b000};
        settle();

        apply_setting(16'd10, 16'd30, 16'd3, 21'd40);
        queue_ticks(400);
        settle();

        // Zero span: position stays at zero
        apply_setting(16'd20, 16'd20, 16'd0, 21'd5);
        queue_ticks(150);
        settle();

        // Negative span
        apply_setting(16'd30, 16'd10, 16'd2, 21'd25);
        queue_ticks(150);
        settle();

        // Huge margin and saturated hold: all low, held flags never rise
        apply_setting(16'd5, 16'd60, 16'hFFFF, HOLD_LIMIT);
        queue_ticks(150);
        settle();

        apply_setting(16'd0, 16'hFFFF, 16'd0, '0);
        queue_ticks(100);
        settle();

        apply_setting(16'hFFFF, 16'd0, 16'd0, 21'd1);
        queue_ticks(100);
        settle();

        // One-tick span drives the position into saturation
        apply_setting(16'd12, 16'd13, 16'd0, 21'd10);
        queue_ticks(150);
        settle();

        // Back-to-back transfers, no idling on either side
        calm = 1'b1;
        apply_setting(16'd1, 16'd40, 16'd5, 21'd60);
        queue_ticks(150);
        settle();

        $display("checked %0d tick results over %0d register settings", n_results,
                 n_settings);
        $display("held flags expected %0d times, saturated positions %0d times",
                 n_held, n_sat);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
